// ===== src/afdc_pkg.sv =====
// ----------------------------------------------------------------------------
// afdc_pkg: shared types and constants for the frame deframer
// Operation codes, result kinds, receiver phases and the result bundle
// passed from the receive engine to the top level.
// ----------------------------------------------------------------------------
package afdc_pkg;

    localparam logic [7:0]  DELIM_BYTE       = 8'h7E;
    localparam logic [7:0]  SUM_INIT         = 8'hFF;
    localparam logic [16:0] NEXT_WAIT_TICKS  = 17'd1;

    localparam logic [15:0] FIRST_TIMEOUT_RESET = 16'd10;
    localparam logic [15:0] STORE_LIMIT_RESET   = 16'd256;

    // Configuration register indexes
    typedef enum logic [0:0] {
        CFG_FIRST_TIMEOUT = 1'b0,
        CFG_STORE_LIMIT   = 1'b1
    } cfg_index_t;

    // Input operation codes
    typedef enum logic [1:0] {
        OP_START = 2'd0,
        OP_BYTE  = 2'd1,
        OP_TICK  = 2'd2
    } op_t;

    // Result kinds
    typedef enum logic [1:0] {
        KIND_DATA    = 2'd0,
        KIND_OK      = 2'd1,
        KIND_TIMEOUT = 2'd2,
        KIND_CRCERR  = 2'd3
    } kind_t;

    // Receiver phases, one-hot
    typedef enum logic [5:0] {
        PH_IDLE    = 6'b000001,
        PH_HUNT    = 6'b000010,
        PH_LENHI   = 6'b000100,
        PH_LENLO   = 6'b001000,
        PH_PAYLOAD = 6'b010000,
        PH_CHECK   = 6'b100000
    } phase_t;

    typedef struct packed {
        logic        valid;
        kind_t       kind;
        logic [7:0]  data_byte;
        logic [15:0] byte_index;
        logic [15:0] frame_length;
    } result_t;

endpackage

// ===== src/afdc_if.sv =====
// ----------------------------------------------------------------------------
// afdc interfaces: valid/ready channels of the frame deframer
// Input word channel, result word channel and configuration write channel.
// ----------------------------------------------------------------------------
interface afdc_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] operation;
    logic [7:0] rx_byte;

    modport source (output valid, output operation, output rx_byte, input ready);
    modport sink   (input valid, input operation, input rx_byte, output ready);
endinterface

interface afdc_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  result_kind;
    logic [7:0]  data_byte;
    logic [15:0] byte_index;
    logic [15:0] frame_length;

    modport source (output valid, output result_kind, output data_byte,
                    output byte_index, output frame_length, input ready);
    modport sink   (input valid, input result_kind, input data_byte,
                    input byte_index, input frame_length, output ready);
endinterface

interface afdc_cfg_if;
    logic        valid;
    logic        ready;
    logic [0:0]  index;
    logic [15:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== src/api_frame_deframer_checksum_top.sv =====
// ----------------------------------------------------------------------------
// api_frame_deframer_checksum_top: framed message receiver with checksum
// A result word is registered and presented in the cycle after its input word is accepted.
// Throughput: one input word per cycle; the output register is refilled in
// the cycle it drains, so only a stalled result holds back the input.
// Reset: receiver idle, timeout 10 ticks, store limit 256, no result held.
// ----------------------------------------------------------------------------
module api_frame_deframer_checksum_top (
    input  logic            clk,
    input  logic            rst_n,
    afdc_in_if.sink         in_ch,
    afdc_out_if.source      out_ch,
    afdc_cfg_if.sink        cfg
);

    logic [15:0]        first_timeout_reg;
    logic [15:0]        store_limit_reg;
    logic               out_valid_reg, out_valid_next;
    logic [1:0]         kind_reg;
    logic [7:0]         data_reg;
    logic [15:0]        index_reg;
    logic [15:0]        length_reg;
    logic               in_accept;
    afdc_pkg::result_t  result;

    // Take a word whenever the result register is free or draining
    assign in_ch.ready = !out_valid_reg || out_ch.ready;
    assign in_accept   = in_ch.valid && in_ch.ready;
    assign cfg.ready   = 1'b1;

    afdc_rx_engine u_engine (
        .clk           (clk),
        .rst_n         (rst_n),
        .step          (in_accept),
        .operation     (in_ch.operation),
        .rx_byte       (in_ch.rx_byte),
        .first_timeout (first_timeout_reg),
        .store_limit   (store_limit_reg),
        .result        (result)
    );

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_timeout_reg <= afdc_pkg::FIRST_TIMEOUT_RESET;
            store_limit_reg   <= afdc_pkg::STORE_LIMIT_RESET;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                afdc_pkg::CFG_FIRST_TIMEOUT: first_timeout_reg <= cfg.data;
                afdc_pkg::CFG_STORE_LIMIT:   store_limit_reg   <= cfg.data;
                default:                     first_timeout_reg <= first_timeout_reg;
            endcase
        end
    end

    // Hold a result until taken, drop it once drained
    always_comb
    begin
        if (in_accept && result.valid)
            out_valid_next = 1'b1;
        else if (out_ch.ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    // Load the result payload
    always_ff @(posedge clk)
    begin
        if (in_accept && result.valid)
        begin
            kind_reg   <= result.kind;
            data_reg   <= result.data_byte;
            index_reg  <= result.byte_index;
            length_reg <= result.frame_length;
        end
    end

    assign out_ch.valid        = out_valid_reg;
    assign out_ch.result_kind  = kind_reg;
    assign out_ch.data_byte    = data_reg;
    assign out_ch.byte_index   = index_reg;
    assign out_ch.frame_length = length_reg;

`ifndef NO_ASSERTIONS
    // Input is only held back by a stalled result
    assert property (@(posedge clk) disable iff (!rst_n)
        !in_ch.ready |-> out_valid_reg && !out_ch.ready)
        else $error("input stalled without a pending result");

    // A produced result is presented in the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        in_accept && result.valid |=> out_ch.valid)
        else $error("result word lost");

    // A word that gives no result and a drained register leave it empty
    assert property (@(posedge clk) disable iff (!rst_n)
        !(in_accept && result.valid) && out_ch.ready |=> !out_ch.valid)
        else $error("result word repeated");
`endif

endmodule

// ===== src/afdc_rx_engine.sv =====
// ----------------------------------------------------------------------------
// afdc_rx_engine: receive state and per-word update
// Holds the receiver phase, length, count, checksum remainder and tick
// counter; works out the result of the current word in one pass.
// ----------------------------------------------------------------------------
module afdc_rx_engine (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                step,
    input  logic [1:0]          operation,
    input  logic [7:0]          rx_byte,
    input  logic [15:0]         first_timeout,
    input  logic [15:0]         store_limit,
    output afdc_pkg::result_t   result
);

    afdc_pkg::phase_t phase_reg, phase_next;
    logic [15:0]      length_reg, length_next;
    logic [15:0]      count_reg, count_next;
    logic [7:0]       sum_reg, sum_next;
    logic [15:0]      ticks_reg, ticks_next;
    logic             first_wait_reg, first_wait_next;

    logic [16:0]      tick_limit;
    logic [16:0]      tick_sum;
    logic [15:0]      count_inc;

    assign tick_limit = first_wait_reg ? {1'b0, first_timeout} : afdc_pkg::NEXT_WAIT_TICKS;
    assign tick_sum   = {1'b0, ticks_reg} + 17'd1;
    assign count_inc  = count_reg + 16'd1;

    // Work out next state and result of the current word
    always_comb
    begin
        phase_next      = phase_reg;
        length_next     = length_reg;
        count_next      = count_reg;
        sum_next        = sum_reg;
        ticks_next      = ticks_reg;
        first_wait_next = first_wait_reg;
        result          = '0;

        if (operation == afdc_pkg::OP_START)
        begin
            phase_next      = afdc_pkg::PH_HUNT;
            length_next     = '0;
            count_next      = '0;
            sum_next        = afdc_pkg::SUM_INIT;
            ticks_next      = '0;
            first_wait_next = 1'b1;
        end
        else if (phase_reg != afdc_pkg::PH_IDLE && operation == afdc_pkg::OP_TICK)
        begin
            if (tick_sum >= tick_limit)
            begin
                phase_next   = afdc_pkg::PH_IDLE;
                ticks_next   = '0;
                result.valid = 1'b1;
                result.kind  = (phase_reg == afdc_pkg::PH_CHECK) ?
                               afdc_pkg::KIND_CRCERR : afdc_pkg::KIND_TIMEOUT;
            end
            else
            begin
                ticks_next = tick_sum[15:0];
            end
        end
        else if (phase_reg != afdc_pkg::PH_IDLE && operation == afdc_pkg::OP_BYTE)
        begin
            ticks_next      = '0;
            first_wait_next = 1'b0;
            case (phase_reg)
                afdc_pkg::PH_HUNT:
                begin
                    if (rx_byte == afdc_pkg::DELIM_BYTE)
                        phase_next = afdc_pkg::PH_LENHI;
                end
                afdc_pkg::PH_LENHI:
                begin
                    length_next = {rx_byte, 8'h00};
                    phase_next  = afdc_pkg::PH_LENLO;
                end
                afdc_pkg::PH_LENLO:
                begin
                    length_next = {length_reg[15:8], rx_byte};
                    count_next  = '0;
                    sum_next    = afdc_pkg::SUM_INIT;
                    phase_next  = ({length_reg[15:8], rx_byte} == 16'd0) ?
                                  afdc_pkg::PH_CHECK : afdc_pkg::PH_PAYLOAD;
                end
                afdc_pkg::PH_PAYLOAD:
                begin
                    sum_next   = sum_reg - rx_byte;
                    count_next = count_inc;
                    if (count_inc == length_reg)
                        phase_next = afdc_pkg::PH_CHECK;
                    if (count_reg < store_limit)
                    begin
                        result.valid      = 1'b1;
                        result.kind       = afdc_pkg::KIND_DATA;
                        result.data_byte  = rx_byte;
                        result.byte_index = count_reg;
                    end
                end
                afdc_pkg::PH_CHECK:
                begin
                    phase_next   = afdc_pkg::PH_IDLE;
                    result.valid = 1'b1;
                    if (rx_byte == sum_reg)
                    begin
                        result.kind         = afdc_pkg::KIND_OK;
                        result.frame_length = length_reg;
                    end
                    else
                    begin
                        result.kind = afdc_pkg::KIND_CRCERR;
                    end
                end
                default:
                begin
                    phase_next = afdc_pkg::PH_IDLE;
                end
            endcase
        end
    end

    // Advance state on each accepted word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= afdc_pkg::PH_IDLE;
            length_reg     <= '0;
            count_reg      <= '0;
            sum_reg        <= afdc_pkg::SUM_INIT;
            ticks_reg      <= '0;
            first_wait_reg <= 1'b1;
        end
        else if (step)
        begin
            phase_reg      <= phase_next;
            length_reg     <= length_next;
            count_reg      <= count_next;
            sum_reg        <= sum_next;
            ticks_reg      <= ticks_next;
            first_wait_reg <= first_wait_next;
        end
    end

`ifndef NO_ASSERTIONS
    // A start word always rearms the hunt with a fresh checksum
    assert property (@(posedge clk) disable iff (!rst_n)
        step && operation == afdc_pkg::OP_START
        |=> phase_reg == afdc_pkg::PH_HUNT && sum_reg == afdc_pkg::SUM_INIT
            && first_wait_reg)
        else $error("start did not rearm the receiver");

    // An idle receiver only reacts to start
    assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == afdc_pkg::PH_IDLE |-> !result.valid)
        else $error("result produced while idle");

    // Every end-of-frame result leaves the receiver idle
    assert property (@(posedge clk) disable iff (!rst_n)
        step && result.valid && result.kind != afdc_pkg::KIND_DATA
        |=> phase_reg == afdc_pkg::PH_IDLE)
        else $error("receiver still armed after end of frame");

    // Payload is only delivered in the payload phase
    assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && result.kind == afdc_pkg::KIND_DATA
        |-> phase_reg == afdc_pkg::PH_PAYLOAD)
        else $error("payload word outside payload phase");
`endif

endmodule
